// ----- sv/bitmap_block_allocator_assert.svh -----
// assertion macros shared by the allocator modules
// each macro expects clk and rst in scope
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checking suspended during reset
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checking suspended during reset
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bba_pkg.sv -----
`timescale 1ns / 1ps

package bba_pkg;

  // field widths
  localparam int BLK_W = 13;
  localparam int CFG_W = 14;
  localparam int ST_W  = 2;

  // sizing
  localparam int DEF_TOTAL_BLOCKS = 8192;
  localparam int INDEX_SPAN       = 8192;
  localparam int BITS_PER_BYTE    = 8;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [ST_W-1:0] STATUS_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] STATUS_RANGE   = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_RESP
  } state_t;

  // request handed to the sequencer
  typedef struct packed {
    logic             op;
    logic [BLK_W-1:0] idx;
  } req_t;

  // response handed back to the top level
  typedef struct packed {
    logic [BLK_W-1:0] index;
    logic [ST_W-1:0]  status;
  } rsp_t;

  // position of the lowest set bit in a byte, 0 when none
  function automatic logic [2:0] lsb_index(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage

// ----- sv/bitmap_block_allocator.sv -----
`timescale 1ns / 1ps
`include "bitmap_block_allocator_assert.svh"

// channel   handshake               payload
// --------  ----------------------  -------------------------
// input     in_valid / in_ready     opcode, block_index
// output    out_valid / out_ready   result_index, status
// config    cfg_we                  cfg_wdata (managed_blocks)
//
// allocate: one bitmap byte read per cycle, first-fit, scanning at most the map bytes,
//   where map bytes is TOTAL_BLOCKS/8 rounded up, capped at 1024
// free: range check and read, write, response, idle; the write is skipped when out of range
// the bitmap memory has one write port and one registered read port, walked by the scan pointer
// after reset a clearing pass fills the map
// a full output register lets the sequencer hold its response until taken

module bitmap_block_allocator #(
  parameter int TOTAL_BLOCKS = bba_pkg::DEF_TOTAL_BLOCKS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      opcode,
  input  logic [bba_pkg::BLK_W-1:0] block_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bba_pkg::BLK_W-1:0] result_index,
  output logic [bba_pkg::ST_W-1:0]  status,
  input  logic                      cfg_we,
  input  logic [bba_pkg::CFG_W-1:0] cfg_wdata
);

  logic [bba_pkg::CFG_W-1:0] managed_blocks;
  logic                      seq_idle;
  logic                      rsp_valid;
  logic                      rsp_take;
  logic                      start;
  bba_pkg::rsp_t             rsp;
  bba_pkg::req_t             req;

  assign in_ready = seq_idle;
  assign start    = in_valid && in_ready;
  assign req      = '{op: opcode, idx: block_index};
  assign rsp_take = rsp_valid && (!out_valid || out_ready);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      managed_blocks <= bba_pkg::CFG_W'(bba_pkg::INDEX_SPAN);
    end else if (cfg_we) begin
      managed_blocks <= cfg_wdata;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (rsp_take) begin
      result_index <= rsp.index;
      status       <= rsp.status;
    end
  end

  bba_seq #(
    .TOTAL_BLOCKS(TOTAL_BLOCKS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .req           (req),
    .managed_blocks(managed_blocks),
    .idle          (seq_idle),
    .rsp_valid     (rsp_valid),
    .rsp_take      (rsp_take),
    .rsp           (rsp)
  );

  `BBA_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
    "new transaction taken while one is in flight")
  `BBA_ASSERT_IMP(a_no_overwrite, rsp_take, !out_valid || out_ready,
    "output register overwritten before it was taken")
  `BBA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(result_index) && $stable(status),
    "output transaction changed while waiting")

endmodule

// ----- sv/bba_seq.sv -----
`timescale 1ns / 1ps
`include "bitmap_block_allocator_assert.svh"

module bba_seq #(
  parameter int TOTAL_BLOCKS = bba_pkg::DEF_TOTAL_BLOCKS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  bba_pkg::req_t             req,
  input  logic [bba_pkg::CFG_W-1:0] managed_blocks,
  output logic                      idle,
  output logic                      rsp_valid,
  input  logic                      rsp_take,
  output bba_pkg::rsp_t             rsp
);

  localparam int CAP       = (TOTAL_BLOCKS < bba_pkg::INDEX_SPAN) ? TOTAL_BLOCKS
                                                                  : bba_pkg::INDEX_SPAN;
  localparam int MAP_BYTES = (CAP + bba_pkg::BITS_PER_BYTE - 1) / bba_pkg::BITS_PER_BYTE;
  localparam int AW        = $clog2(MAP_BYTES);
  localparam logic [AW:0]               PTR_END  = (AW + 1)'(MAP_BYTES);
  localparam logic [AW-1:0]             LAST_ADR = AW'(MAP_BYTES - 1);
  localparam logic [bba_pkg::CFG_W-1:0] CAP_W    = bba_pkg::CFG_W'(CAP);

  // bitmap storage, one byte per entry, 1 = free
  logic [7:0] mem [MAP_BYTES];
  logic [7:0] rd_data;

  bba_pkg::state_t state, state_next;
  logic [AW-1:0] clr_ptr, clr_ptr_next;
  logic [AW:0]   scan_ptr, scan_ptr_next;
  logic          chk_vld, chk_vld_next;
  logic [AW-1:0] chk_addr, chk_addr_next;

  logic                      op_q, op_q_next;
  logic [bba_pkg::BLK_W-1:0] idx_q, idx_q_next;
  bba_pkg::rsp_t             rsp_q, rsp_q_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [bba_pkg::CFG_W-1:0] lim;
  logic [bba_pkg::CFG_W-1:0] base;
  logic [bba_pkg::CFG_W-1:0] blk;
  logic [7:0]                data_m;
  logic [2:0]                hit_bit;

  // effective limit
  assign lim = (managed_blocks > CAP_W) ? CAP_W : managed_blocks;

  // byte under test in the scan
  assign base    = bba_pkg::CFG_W'({chk_addr, 3'b000});
  assign data_m  = rd_data & ((chk_addr == '0) ? 8'hFE : 8'hFF);
  assign hit_bit = bba_pkg::lsb_index(data_m);
  assign blk     = base | bba_pkg::CFG_W'(hit_bit);

  assign idle      = (state == bba_pkg::ST_IDLE);
  assign rsp_valid = (state == bba_pkg::ST_RESP);
  assign rsp       = rsp_q;

  // next state and memory controls
  always_comb begin
    state_next    = state;
    clr_ptr_next  = clr_ptr;
    scan_ptr_next = scan_ptr;
    chk_vld_next  = chk_vld;
    chk_addr_next = chk_addr;
    op_q_next     = op_q;
    idx_q_next    = idx_q;
    rsp_q_next    = rsp_q;
    mem_we        = 1'b0;
    mem_waddr     = clr_ptr;
    mem_wdata     = 8'hFF;
    mem_raddr     = idx_q[AW+2:3];

    case (state)
      bba_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr;
        mem_wdata = (clr_ptr == '0) ? 8'hFE : 8'hFF;
        clr_ptr_next = clr_ptr + 1'b1;
        if (clr_ptr == LAST_ADR) state_next = bba_pkg::ST_IDLE;
      end

      bba_pkg::ST_IDLE: begin
        if (start) begin
          op_q_next     = req.op;
          idx_q_next    = req.idx;
          scan_ptr_next = '0;
          chk_vld_next  = 1'b0;
          state_next    = (req.op == bba_pkg::OP_ALLOC) ? bba_pkg::ST_SCAN
                                                        : bba_pkg::ST_FREE_RD;
        end
      end

      bba_pkg::ST_SCAN: begin
        mem_raddr = scan_ptr[AW-1:0];
        if (chk_vld && (base >= lim)) begin
          // scan has reached the limit
          rsp_q_next = '{index: '0, status: bba_pkg::STATUS_NOSPACE};
          state_next = bba_pkg::ST_RESP;
        end else if (chk_vld && (data_m != 8'h00)) begin
          if (blk < lim) begin
            mem_we     = 1'b1;
            mem_waddr  = chk_addr;
            mem_wdata  = rd_data & ~(8'(1) << hit_bit);
            rsp_q_next = '{index: blk[bba_pkg::BLK_W-1:0], status: bba_pkg::STATUS_OK};
          end else begin
            rsp_q_next = '{index: '0, status: bba_pkg::STATUS_NOSPACE};
          end
          state_next = bba_pkg::ST_RESP;
        end else if (scan_ptr < PTR_END) begin
          // issue the next byte read
          chk_vld_next  = 1'b1;
          chk_addr_next = scan_ptr[AW-1:0];
          scan_ptr_next = scan_ptr + 1'b1;
        end else if (chk_vld) begin
          chk_vld_next = 1'b0;
        end else begin
          rsp_q_next = '{index: '0, status: bba_pkg::STATUS_NOSPACE};
          state_next = bba_pkg::ST_RESP;
        end
      end

      bba_pkg::ST_FREE_RD: begin
        if ((idx_q == '0) || (bba_pkg::CFG_W'(idx_q) >= lim)) begin
          rsp_q_next = '{index: idx_q, status: bba_pkg::STATUS_RANGE};
          state_next = bba_pkg::ST_RESP;
        end else begin
          state_next = bba_pkg::ST_FREE_WR;
        end
      end

      bba_pkg::ST_FREE_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_q[AW+2:3];
        mem_wdata  = rd_data | (8'(1) << idx_q[2:0]);
        rsp_q_next = '{index: idx_q, status: bba_pkg::STATUS_OK};
        state_next = bba_pkg::ST_RESP;
      end

      bba_pkg::ST_RESP: begin
        if (rsp_take) state_next = bba_pkg::ST_IDLE;
      end

      default: begin
        state_next = bba_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bba_pkg::ST_CLEAR;
      clr_ptr  <= '0;
      scan_ptr <= '0;
      chk_vld  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_ptr  <= clr_ptr_next;
      scan_ptr <= scan_ptr_next;
      chk_vld  <= chk_vld_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_addr <= chk_addr_next;
    op_q     <= op_q_next;
    idx_q    <= idx_q_next;
    rsp_q    <= rsp_q_next;
  end

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[mem_raddr];
  end

  `BBA_ASSERT_IMP(a_alloc_never_zero,
    rsp_valid && (rsp.status == bba_pkg::STATUS_OK) && (op_q == bba_pkg::OP_ALLOC),
    rsp.index != '0, "allocation handed out reserved block 0")
  `BBA_ASSERT_IMP(a_ok_below_limit, rsp_valid && (rsp.status == bba_pkg::STATUS_OK),
    bba_pkg::CFG_W'(rsp.index) < lim, "successful result at or above the limit")
  `BBA_ASSERT_IMP(a_scan_ptr_bound, 1'b1, scan_ptr <= PTR_END, "scan pointer past the map")
  `BBA_ASSERT_IMP(a_write_states, mem_we,
    (state == bba_pkg::ST_CLEAR) || (state == bba_pkg::ST_SCAN) ||
    (state == bba_pkg::ST_FREE_WR), "bitmap written outside a writing state")

endmodule
